// ----- hw/rtl/tssm_pkg.sv -----
// Shared types and constants for the two-stacks shared memory unit.
// No dependencies; used by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package tssm_pkg;

   localparam int ReqDataW  = 40;
   localparam int RspDataW  = 48;
   localparam int WordW     = 32;
   localparam int CmdW      = 3;
   localparam int StatusW   = 2;
   localparam int CountW    = 5;

   typedef enum logic [CmdW-1:0] {
      CMD_PUSH_ONE = 3'd0,
      CMD_PUSH_TWO = 3'd1,
      CMD_POP_ONE  = 3'd2,
      CMD_POP_TWO  = 3'd3,
      CMD_PEEK_ONE = 3'd4,
      CMD_PEEK_TWO = 3'd5
   } cmd_type;

   typedef enum logic [StatusW-1:0] {
      ST_OK        = 2'd0,
      ST_OVERFLOW  = 2'd1,
      ST_UNDERFLOW = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE = 2'd0,
      S_EXEC = 2'd1,
      S_RESP = 2'd2
   } state_type;

   // Controller to datapath commands.
   typedef struct packed {
      logic load;   // capture the request fields
      logic exec;   // perform the operation and the memory access
   } dp_cmd_type;

endpackage

// ----- hw/rtl/tssm_ctrl.sv -----
// Sequencer for the two-stacks shared memory unit.
// Depends on tssm_pkg for the state and datapath command types.
`timescale 1ns / 1ps

module tssm_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output tssm_pkg::dp_cmd_type dp_cmd
);

   tssm_pkg::state_type state_ff;
   tssm_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tssm_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      req_tready  = 1'b0;
      rsp_tvalid  = 1'b0;
      dp_cmd.load = 1'b0;
      dp_cmd.exec = 1'b0;
      case (state_ff)
         tssm_pkg::S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               dp_cmd.load = 1'b1;
               state_in    = tssm_pkg::S_EXEC;
            end
         end
         tssm_pkg::S_EXEC: begin
            dp_cmd.exec = 1'b1;
            state_in    = tssm_pkg::S_RESP;
         end
         tssm_pkg::S_RESP: begin
            // hold the result until the transfer completes
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               state_in = tssm_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = tssm_pkg::S_IDLE;
         end
      endcase
   end

endmodule

// ----- hw/rtl/tssm_datapath.sv -----
// Datapath of the two-stacks shared memory unit: stack depths, shared word
// memory and result registers. Depends on tssm_pkg for types and widths.
`timescale 1ns / 1ps

module tssm_datapath #(
   parameter int DEPTH = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  tssm_pkg::dp_cmd_type               dp_cmd,
   input  logic [tssm_pkg::CmdW-1:0]          cmd,
   input  logic signed [tssm_pkg::WordW-1:0]  push_value,
   output logic signed [tssm_pkg::WordW-1:0]  read_value,
   output logic [tssm_pkg::StatusW-1:0]       status,
   output logic [tssm_pkg::CountW-1:0]        count_one,
   output logic [tssm_pkg::CountW-1:0]        count_two
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [CW-1:0] DepthCw  = CW'(DEPTH);
   localparam logic [CW:0]   DepthSum = (CW + 1)'(DEPTH);

   tssm_pkg::cmd_type                cmd_ff;
   logic signed [tssm_pkg::WordW-1:0] value_ff;
   logic [CW-1:0]                    depth_one_ff, depth_one_in;
   logic [CW-1:0]                    depth_two_ff, depth_two_in;
   logic [tssm_pkg::WordW-1:0]       store [DEPTH];
   logic [tssm_pkg::WordW-1:0]       rd_data_ff;
   tssm_pkg::status_type             status_ff, status_in;
   logic                             use_mem_ff, use_mem_in;

   logic [CW:0]   used_sum;
   logic          full;
   logic [CW-1:0] top_one;     // stack one top word
   logic [CW-1:0] top_two;     // stack two top word
   logic [CW-1:0] below_two;   // next free word of stack two
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [AW-1:0] rd_addr;

   always_comb begin
      used_sum     = {1'b0, depth_one_ff} + {1'b0, depth_two_ff};
      full         = (used_sum >= DepthSum);
      top_one      = depth_one_ff - CW'(1);
      top_two      = DepthCw - depth_two_ff;
      below_two    = top_two - CW'(1);
      depth_one_in = depth_one_ff;
      depth_two_in = depth_two_ff;
      status_in    = tssm_pkg::ST_OK;
      use_mem_in   = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = depth_one_ff[AW-1:0];
      rd_addr      = top_one[AW-1:0];
      case (cmd_ff)
         tssm_pkg::CMD_PUSH_ONE: begin
            if (full) begin
               status_in = tssm_pkg::ST_OVERFLOW;
            end else begin
               wr_en        = 1'b1;
               depth_one_in = depth_one_ff + CW'(1);
            end
         end
         tssm_pkg::CMD_PUSH_TWO: begin
            wr_addr = below_two[AW-1:0];
            if (full) begin
               status_in = tssm_pkg::ST_OVERFLOW;
            end else begin
               wr_en        = 1'b1;
               depth_two_in = depth_two_ff + CW'(1);
            end
         end
         tssm_pkg::CMD_POP_ONE, tssm_pkg::CMD_PEEK_ONE: begin
            if (depth_one_ff == '0) begin
               status_in = tssm_pkg::ST_UNDERFLOW;
            end else begin
               use_mem_in = 1'b1;
               if (cmd_ff == tssm_pkg::CMD_POP_ONE) begin
                  depth_one_in = top_one;
               end
            end
         end
         tssm_pkg::CMD_POP_TWO, tssm_pkg::CMD_PEEK_TWO: begin
            rd_addr = top_two[AW-1:0];
            if (depth_two_ff == '0) begin
               status_in = tssm_pkg::ST_UNDERFLOW;
            end else begin
               use_mem_in = 1'b1;
               if (cmd_ff == tssm_pkg::CMD_POP_TWO) begin
                  depth_two_in = depth_two_ff - CW'(1);
               end
            end
         end
         default: begin
            // unused codes: no change, plain ok result
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_one_ff <= '0;
         depth_two_ff <= '0;
      end else if (dp_cmd.exec) begin
         depth_one_ff <= depth_one_in;
         depth_two_ff <= depth_two_in;
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.load) begin
         cmd_ff   <= tssm_pkg::cmd_type'(cmd);
         value_ff <= push_value;
      end
      if (dp_cmd.exec) begin
         status_ff  <= status_in;
         use_mem_ff <= use_mem_in;
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.exec && wr_en) begin
         store[wr_addr] <= value_ff;
      end
      if (dp_cmd.exec) begin
         rd_data_ff <= store[rd_addr];
      end
   end

   always_comb begin
      if (use_mem_ff) begin
         read_value = rd_data_ff;
      end else if (status_ff == tssm_pkg::ST_UNDERFLOW) begin
         read_value = '1;
      end else begin
         read_value = '0;
      end
   end

   assign status    = status_ff;
   assign count_one = tssm_pkg::CountW'(depth_one_ff);
   assign count_two = tssm_pkg::CountW'(depth_two_ff);

endmodule

// ----- hw/rtl/two_stacks_shared_memory_unit.sv -----
// Two stacks sharing one memory: top level. After the request transfer the
// unit executes the command with one memory access, then presents the
// registered result on rsp_tvalid. One item at a time: a new request is taken
// the cycle after the response transfer, so items never overlap; this is set
// by the sequencer. Synchronous active-high reset empties both
// stacks; memory words are not cleared and hold no meaning until pushed.
// Depends on tssm_pkg, tssm_ctrl and tssm_datapath.
`timescale 1ns / 1ps

module two_stacks_shared_memory_unit #(
   parameter int DEPTH = 16   // shared words, 2 .. 31
) (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [tssm_pkg::ReqDataW-1:0]   req_tdata,  // cmd[2:0], push_value[34:3]
   // response channel
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [tssm_pkg::RspDataW-1:0]   rsp_tdata   // read_value[31:0], status[33:32],
                                                       // count_one[38:34], count_two[43:39]
);

   tssm_pkg::dp_cmd_type dp_cmd;

   logic [tssm_pkg::CmdW-1:0]          req_cmd;
   logic signed [tssm_pkg::WordW-1:0]  req_push_value;
   logic signed [tssm_pkg::WordW-1:0]  rsp_read_value;
   logic [tssm_pkg::StatusW-1:0]       rsp_status;
   logic [tssm_pkg::CountW-1:0]        rsp_count_one;
   logic [tssm_pkg::CountW-1:0]        rsp_count_two;

   // Unpack the request transfer; upper pad bits carry nothing.
   assign req_cmd        = req_tdata[2:0];
   assign req_push_value = req_tdata[34:3];

   // Sequencer: idle, execute, present response.
   tssm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .dp_cmd     (dp_cmd)
   );

   // Stack pointers, shared memory and result registers.
   tssm_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .dp_cmd     (dp_cmd),
      .cmd        (req_cmd),
      .push_value (req_push_value),
      .read_value (rsp_read_value),
      .status     (rsp_status),
      .count_one  (rsp_count_one),
      .count_two  (rsp_count_two)
   );

   // Pack the response, lowest field first, zero padded to whole bytes.
   assign rsp_tdata = {4'b0000, rsp_count_two, rsp_count_one, rsp_status, rsp_read_value};

endmodule
